// File: design/qrm_pkg.sv
// Shared widths and constants for the quaternion to rotation matrix unit.
// No dependencies; imported by qrm_div_lane and the top level.
package qrm_pkg;

  // Input components and result entries are Q1.15.
  localparam int unsigned CompW = 16;
  // Number of matrix entries produced per request.
  localparam int unsigned NumEnt = 9;
  // Quotient bits; one divider stage resolves one bit.
  localparam int unsigned QuoW = 16;
  // Squared norm (unsigned) and signed numerators.
  localparam int unsigned NormW = 33;
  localparam int unsigned NumW = 34;
  // Divisor 2n and dividend |num| * 2^16 + n.
  localparam int unsigned DvsW = NormW + 1;
  localparam int unsigned DvdW = NormW + QuoW + 1;

  // Saturation limits of the Q1.15 result.
  localparam logic [QuoW-1:0] PosMax = 16'h7fff;
  localparam logic [QuoW-1:0] NegMax = 16'h8000;

  // Pipeline control shared by all divider lanes.
  typedef struct packed {
    logic en;
  } pipe_ctrl_t;

endpackage

// File: design/quaternion_to_rotation_matrix_unit.sv
// Top level: quaternion (Q1.15) to normalized 3x3 rotation matrix (Q1.15).
// Depends on qrm_pkg and qrm_div_lane.
//
//   channel   valid     stall     payload
//   input     valid_i   stall_o   qx_i qy_i qz_i qw_i
//   output    valid_o   stall_i   r00_o .. r22_o zero_norm_o
//
// One request per cycle while the pipeline is not held; the stages are products, sums,
// dividend setup, 16 divider stages (one quotient bit each) and the output register.
// The whole pipeline advances together; it holds only while a result waits
// in the output register and stall_i is high.
// Reset clears the valid bits only; the datapath needs no reset.
module quaternion_to_rotation_matrix_unit
  import qrm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [CompW-1:0] qx_i,
  input  logic signed [CompW-1:0] qy_i,
  input  logic signed [CompW-1:0] qz_i,
  input  logic signed [CompW-1:0] qw_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic signed [CompW-1:0] r00_o,
  output logic signed [CompW-1:0] r01_o,
  output logic signed [CompW-1:0] r02_o,
  output logic signed [CompW-1:0] r10_o,
  output logic signed [CompW-1:0] r11_o,
  output logic signed [CompW-1:0] r12_o,
  output logic signed [CompW-1:0] r20_o,
  output logic signed [CompW-1:0] r21_o,
  output logic signed [CompW-1:0] r22_o,
  output logic                    zero_norm_o
);

  localparam int unsigned PW = 2 * CompW;

  pipe_ctrl_t ctrl;
  logic       en;

  // The pipeline moves unless a finished result is held.
  assign en       = !(valid_o && stall_i);
  assign ctrl.en  = en;
  assign stall_o  = !en;

  // Stage 1: the ten component products.
  logic              v1_q;
  logic signed [PW-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q <= qx_i * qx_i;
      yy_q <= qy_i * qy_i;
      zz_q <= qz_i * qz_i;
      ww_q <= qw_i * qw_i;
      xy_q <= qx_i * qy_i;
      zw_q <= qz_i * qw_i;
      xz_q <= qx_i * qz_i;
      yw_q <= qy_i * qw_i;
      yz_q <= qy_i * qz_i;
      xw_q <= qx_i * qw_i;
    end
  end

  // Stage 2: squared norm and the nine numerators.
  logic                  v2_q;
  logic [NormW-1:0]      n_q;
  logic signed [NumW-1:0] num_q [NumEnt];
  logic signed [NumW-1:0] exx, eyy, ezz, eww, exy, ezw, exz, eyw, eyz, exw;
  logic signed [NumW-1:0] n_sum;

  always_comb begin
    exx   = NumW'(xx_q);
    eyy   = NumW'(yy_q);
    ezz   = NumW'(zz_q);
    eww   = NumW'(ww_q);
    exy   = NumW'(xy_q);
    ezw   = NumW'(zw_q);
    exz   = NumW'(xz_q);
    eyw   = NumW'(yw_q);
    eyz   = NumW'(yz_q);
    exw   = NumW'(xw_q);
    n_sum = exx + eyy + ezz + eww;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q      <= n_sum[NormW-1:0];
      num_q[0] <= exx - eyy - ezz + eww;
      num_q[1] <= (exy - ezw) <<< 1;
      num_q[2] <= (exz + eyw) <<< 1;
      num_q[3] <= (exy + ezw) <<< 1;
      num_q[4] <= eyy - exx - ezz + eww;
      num_q[5] <= (eyz - exw) <<< 1;
      num_q[6] <= (exz - eyw) <<< 1;
      num_q[7] <= (eyz + exw) <<< 1;
      num_q[8] <= ezz - exx - eyy + eww;
    end
  end

  // Stage 3: sign, magnitude and rounded dividend per entry.
  logic              v3_q;
  logic              zero3_q;
  logic [NumEnt-1:0] neg3_q;
  logic [DvdW-1:0]   dvd_q [NumEnt];
  logic [DvsW-1:0]   dvs_q;

  for (genvar k = 0; k < NumEnt; k++) begin : g_prep
    logic [NumW-1:0] mag;
    assign mag = num_q[k][NumW-1] ? NumW'(-num_q[k]) : NumW'(num_q[k]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        neg3_q[k] <= num_q[k][NumW-1];
        dvd_q[k]  <= (DvdW'(mag[NormW-1:0]) << (QuoW + 1 - 1)) + DvdW'(n_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvs_q   <= {n_q, 1'b0};
      zero3_q <= (n_q == '0);
    end
  end

  // Divider lanes, one per entry.
  logic [QuoW-1:0] quo [NumEnt];

  for (genvar k = 0; k < NumEnt; k++) begin : g_lane
    qrm_div_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .dvd_i  (dvd_q[k]),
      .dvs_i  (dvs_q),
      .quo_o  (quo[k])
    );
  end

  // Sign and zero flag ride alongside the divider stages.
  logic [NumEnt-1:0] neg_q  [QuoW];
  logic              zero_q [QuoW];
  logic              vd_q   [QuoW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q[0]  <= neg3_q;
      zero_q[0] <= zero3_q;
      for (int s = 1; s < QuoW; s++) begin
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  // Valid bits of the whole pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_o <= 1'b0;
      for (int s = 0; s < QuoW; s++) begin
        vd_q[s] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vd_q[0] <= v3_q;
      for (int s = 1; s < QuoW; s++) begin
        vd_q[s] <= vd_q[s-1];
      end
      valid_o <= vd_q[QuoW-1];
    end
  end

  // Output stage: saturate, apply sign, force zero for a zero quaternion.
  logic [CompW-1:0] ent_d [NumEnt];
  logic [CompW-1:0] ent_q [NumEnt];
  logic             zero_out_q;

  for (genvar k = 0; k < NumEnt; k++) begin : g_sat
    always_comb begin
      if (zero_q[QuoW-1]) begin
        ent_d[k] = '0;
      end else if (neg_q[QuoW-1][k]) begin
        ent_d[k] = (quo[k] > NegMax) ? NegMax : CompW'(-quo[k]);
      end else begin
        ent_d[k] = (quo[k] > PosMax) ? PosMax : CompW'(quo[k]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ent_q[k] <= ent_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_out_q <= zero_q[QuoW-1];
    end
  end

  assign r00_o       = ent_q[0];
  assign r01_o       = ent_q[1];
  assign r02_o       = ent_q[2];
  assign r10_o       = ent_q[3];
  assign r11_o       = ent_q[4];
  assign r12_o       = ent_q[5];
  assign r20_o       = ent_q[6];
  assign r21_o       = ent_q[7];
  assign r22_o       = ent_q[8];
  assign zero_norm_o = zero_out_q;

`ifndef SYNTHESIS
  // A zero quaternion must give an all-zero matrix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_norm_o |-> (r00_o == 0) && (r01_o == 0) && (r02_o == 0) &&
      (r10_o == 0) && (r11_o == 0) && (r12_o == 0) && (r20_o == 0) &&
      (r21_o == 0) && (r22_o == 0))
    else $error("zero quaternion gave a nonzero entry");

  // The trace of a rotation never falls below -1, up to rounding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !zero_norm_o |->
      ((18'(signed'(r00_o)) + 18'(signed'(r11_o)) + 18'(signed'(r22_o)))
        >= -18'sd32771))
    else $error("rotation trace out of range");

  // A result held by the consumer is still there in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(r00_o) && $stable(zero_norm_o))
    else $error("held result lost");
`endif

endmodule

// File: design/qrm_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per register stage.
// Depends on qrm_pkg for widths and the pipeline control struct.
module qrm_div_lane
  import qrm_pkg::*;
(
  input  logic            clk_i,
  input  pipe_ctrl_t      ctrl_i,
  input  logic [DvdW-1:0] dvd_i,
  input  logic [DvsW-1:0] dvs_i,
  output logic [QuoW-1:0] quo_o
);

  logic [DvdW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic [DvsW-1:0] dvs_q [QuoW-1];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [DvdW-1:0] rem_in;
    logic [DvsW-1:0] dvs_in;
    logic [QuoW-1:0] quo_in;
    logic [DvdW-1:0] sub_val;
    logic            take;
    logic [DvdW-1:0] rem_d;
    logic [QuoW-1:0] quo_d;

    // Stage inputs come from the ports or from the previous stage.
    if (s == 0) begin : g_first
      assign rem_in = dvd_i;
      assign dvs_in = dvs_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dvs_in = dvs_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // Trial subtract of the divisor aligned to this quotient bit.
    always_comb begin
      sub_val = DvdW'(dvs_in) << (QuoW - 1 - s);
      take    = (rem_in >= sub_val);
      rem_d   = take ? (rem_in - sub_val) : rem_in;
      quo_d   = quo_in | (take ? (QuoW'(1) << (QuoW - 1 - s)) : '0);
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
      end
    end

    // The divisor is carried only as far as a later stage needs it.
    if (s < QuoW - 1) begin : g_dvs
      always_ff @(posedge clk_i) begin
        if (ctrl_i.en) begin
          dvs_q[s] <= dvs_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule
